[sv/substring_presence_matcher_macros.svh]
// Assertion helpers used by the matcher top level.
`ifndef SUBSTRING_PRESENCE_MATCHER_MACROS_SVH
`define SUBSTRING_PRESENCE_MATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPM_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPM_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/spm_pkg.sv]
`default_nettype none
package spm_pkg;

	// Window and pattern store depth
	localparam int PATTERN_MAX = 32;
	localparam int IDX_W       = $clog2(PATTERN_MAX);
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

	// Item field widths
	localparam int KIND_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int LOAD_W  = 5;
	localparam int PLEN_W  = 6;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam int REG_IDX_LSB = 2;
	localparam logic [PADDR_W-REG_IDX_LSB-1:0] REG_PATTERN_LENGTH = '0;

	// Item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD = 2'd0,
		KIND_TEXT = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	// One queued command
	typedef struct packed {
		kind_t               op;
		logic [CHAR_W-1:0]   ch;
		logic [LOAD_W-1:0]   idx;
	} cmd_t;

endpackage
`default_nettype wire

[sv/spm_if.sv]
`default_nettype none
interface spm_in_if;
	import spm_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [CHAR_W-1:0] char_value;
	logic [LOAD_W-1:0] load_index;

	modport source (output valid, kind, char_value, load_index, input ready);
	modport sink (input valid, kind, char_value, load_index, output ready);
endinterface

interface spm_out_if;
	logic valid;
	logic ready;
	logic found;

	modport source (output valid, found, input ready);
	modport sink (input valid, found, output ready);
endinterface
`default_nettype wire

[sv/spm_front.sv]
`default_nettype none
module spm_front (
	input  logic          clk,
	input  logic          arst_n,
	spm_in_if.sink        items,
	output spm_pkg::cmd_t head,
	output logic          head_valid,
	input  logic          head_pop
);
	import spm_pkg::*;

	cmd_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              new_cmd;
	logic              keep_cmd;
	logic              push;
	logic              pop;

	// Accept whenever the queue has room
	assign items.ready = (count_q != QCNT_W'(QUEUE_DEPTH));

	// Classify the item; drop the unused kind
	always_comb begin
		new_cmd.op  = KIND_TEXT;
		new_cmd.ch  = items.char_value;
		new_cmd.idx = items.load_index;
		keep_cmd    = 1'b1;
		case (items.kind)
			KIND_LOAD: new_cmd.op = KIND_LOAD;
			KIND_TEXT: new_cmd.op = KIND_TEXT;
			KIND_END:  new_cmd.op = KIND_END;
			default:   keep_cmd   = 1'b0;
		endcase
	end

	assign push = items.valid && items.ready && keep_cmd;
	assign pop  = head_pop && head_valid;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head       = queue_q[rd_ptr_q];
	assign head_valid = (count_q != '0);

endmodule
`default_nettype wire

[sv/spm_back.sv]
`default_nettype none
module spm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  spm_pkg::cmd_t              head,
	input  logic                       head_valid,
	output logic                       head_pop,
	input  logic [spm_pkg::PLEN_W-1:0] pattern_length,
	spm_out_if.source                  results
);
	import spm_pkg::*;

	logic [CHAR_W-1:0]      pattern_q [PATTERN_MAX];
	logic [CHAR_W-1:0]      window_q  [PATTERN_MAX];
	logic [LEN_W-1:0]       count_q;
	logic                   match_q;
	logic                   check_s1;
	logic                   out_valid_q;
	logic                   found_q;
	logic                   out_free;
	logic                   do_load;
	logic                   do_text;
	logic                   do_end;
	logic [PATTERN_MAX-1:0] pos_eq;
	logic                   len_ok;
	logic                   hit;

	// Take a command unless it is an end item and the result slot is busy
	assign out_free = !out_valid_q || results.ready;
	assign head_pop = head_valid && ((head.op != KIND_END) || out_free);
	assign do_load  = head_pop && (head.op == KIND_LOAD);
	assign do_text  = head_pop && (head.op == KIND_TEXT);
	assign do_end   = head_pop && (head.op == KIND_END);

	// Compare each pattern byte against its window tap
	always_comb begin
		logic [PLEN_W-1:0] tap;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			tap = pattern_length - PLEN_W'(k) - PLEN_W'(1);
			if (PLEN_W'(k) < pattern_length) begin
				pos_eq[k] = (window_q[tap[IDX_W-1:0]] == pattern_q[k]);
			end else begin
				pos_eq[k] = 1'b1;
			end
		end
	end

	assign len_ok = (pattern_length != '0)
		&& (pattern_length <= PLEN_W'(PATTERN_MAX))
		&& (PLEN_W'(count_q) >= pattern_length);
	assign hit = check_s1 && len_ok && (&pos_eq);

	// Pattern store and text window
	always_ff @(posedge clk) begin
		if (do_load) begin
			pattern_q[head.idx[IDX_W-1:0]] <= head.ch;
		end
		if (do_text) begin
			window_q[0] <= head.ch;
			for (int k = 1; k < PATTERN_MAX; k++) begin
				window_q[k] <= window_q[k-1];
			end
		end
	end

	// Count, sticky match, pending compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			match_q  <= 1'b0;
			check_s1 <= 1'b0;
		end else begin
			check_s1 <= do_text;
			if (do_end) begin
				count_q <= '0;
				match_q <= 1'b0;
			end else begin
				if (do_text && (count_q != LEN_W'(PATTERN_MAX))) begin
					count_q <= count_q + LEN_W'(1);
				end
				if (hit) begin
					match_q <= 1'b1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_end) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_end) begin
			found_q <= match_q || hit || (pattern_length == '0);
		end
	end

	assign results.valid = out_valid_q;
	assign results.found = found_q;

endmodule
`default_nettype wire

[sv/substring_presence_matcher.sv]
// Substring presence matcher: load pattern bytes with kind 0 items, set pattern_length
// (register 0, at most 32) while idle, then stream text with kind 1 items and close each
// text with a kind 2 item, which returns one result, found. The block accepts one item per
// clock cycle; a front queue of four commands decouples input from the executing back end,
// so intake only stalls when the queue fills. The per-byte rate is set by the window compare,
// a 32-way tap select plus byte compare, evaluated in the cycle after each text byte. A
// result is registered when its end item leaves the queue, and holds until taken. Kind 3
// items are accepted and dropped. An empty pattern always reports found.
`default_nettype none
`include "substring_presence_matcher_macros.svh"
module substring_presence_matcher (
	input  logic                        clk,
	input  logic                        arst_n,
	spm_in_if.sink                      items,
	spm_out_if.source                   results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [spm_pkg::PADDR_W-1:0] paddr,
	input  logic [spm_pkg::PDATA_W-1:0] pwdata,
	output logic [spm_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import spm_pkg::*;

	cmd_t              head;
	logic              head_valid;
	logic              head_pop;
	logic [PLEN_W-1:0] pattern_length_q;
	logic              reg_hit;

	// Register decode
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:REG_IDX_LSB] == REG_PATTERN_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			pattern_length_q <= pwdata[PLEN_W-1:0];
		end
	end

	assign prdata = reg_hit ? {{(PDATA_W-PLEN_W){1'b0}}, pattern_length_q} : '0;

	spm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop)
	);

	spm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.head_valid     (head_valid),
		.head_pop       (head_pop),
		.pattern_length (pattern_length_q),
		.results        (results)
	);

	`SPM_ASSERT_IMPL(a_pop_needs_head, clk, arst_n, head_pop, head_valid, "pop from empty queue")
	`SPM_ASSERT_IMPL(a_full_has_head, clk, arst_n, !items.ready, head_valid, "stall with empty queue")
	`SPM_ASSERT_IMPL(a_end_needs_room, clk, arst_n, head_pop && (head.op == KIND_END), !results.valid || results.ready, "end item overwrote result")
	`SPM_ASSERT_NEXT(a_end_gives_result, clk, arst_n, head_pop && (head.op == KIND_END), results.valid, "end item without result")

endmodule
`default_nettype wire

[tb/substring_presence_matcher_tb.sv]
`timescale 1ns / 1ps
module substring_presence_matcher_tb;
	import spm_pkg::*;

	typedef logic [CHAR_W-1:0] char_t;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [PADDR_W-1:0] PATTERN_LENGTH_ADDR =
		PADDR_W'(REG_PATTERN_LENGTH) << REG_IDX_LSB;
	localparam int RANDOM_ITEMS = 550;
	localparam int DRAIN_CYCLES = 3 * (QUEUE_DEPTH + 2);
	localparam int TIMEOUT_NS = 2_000_000;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	spm_in_if items_ch ();
	spm_out_if results_ch ();

	substring_presence_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Search state mirrored from the block
	char_t pattern_mem [PATTERN_MAX];
	char_t text_window [PATTERN_MAX];
	int unsigned chars_seen;
	bit match_seen;
	logic [PLEN_W-1:0] pattern_length;

	bit expected_found [$];

	int errors;
	int items_sent;
	int texts_closed;
	int results_checked;
	int found_count;
	int burst_left;

	// Clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop
	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

	// Update the mirrored search state for one accepted item
	task automatic advance_search(input logic [KIND_W-1:0] kind, input char_t ch,
			input logic [LOAD_W-1:0] idx);
		int k;
		bit hit_now;
		case (kind)
			KIND_LOAD: begin
				pattern_mem[idx] = ch;
			end
			KIND_TEXT: begin
				for (k = PATTERN_MAX - 1; k > 0; k--)
					text_window[k] = text_window[k - 1];
				text_window[0] = ch;
				if (chars_seen < PATTERN_MAX)
					chars_seen++;
				if (pattern_length != 0 && pattern_length <= PATTERN_MAX &&
						chars_seen >= pattern_length) begin
					hit_now = 1'b1;
					for (k = 0; k < pattern_length; k++)
						if (text_window[pattern_length - 1 - k] != pattern_mem[k])
							hit_now = 1'b0;
					if (hit_now)
						match_seen = 1'b1;
				end
			end
			KIND_END: begin
				expected_found.push_back(match_seen || pattern_length == 0);
				match_seen = 1'b0;
				chars_seen = 0;
				texts_closed++;
			end
			default: ;
		endcase
	endtask

	// Offer one item, in bursts with random gaps, and hold it until accepted
	task automatic send_item(input logic [KIND_W-1:0] kind, input char_t ch,
			input logic [LOAD_W-1:0] idx);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				items_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		items_ch.valid <= 1'b1;
		items_ch.kind <= kind;
		items_ch.char_value <= ch;
		items_ch.load_index <= idx;
		do @(posedge clk); while (!items_ch.ready);
		advance_search(kind, ch, idx);
		if (kind != KIND_UNUSED)
			items_sent++;
	endtask

	// Load pattern bytes at positions 0 upward
	task automatic load_pattern(input char_t pat_q[$]);
		int i;
		for (i = 0; i < pat_q.size(); i++)
			send_item(KIND_LOAD, pat_q[i], LOAD_W'(i));
	endtask

	// Stream one text and close it, optionally mixing in stray items
	task automatic send_text(input char_t text_q[$], input bit with_noise);
		int i;
		for (i = 0; i < text_q.size(); i++) begin
			if (with_noise && $urandom_range(0, 29) == 0) begin
				if ($urandom_range(0, 1) == 0)
					send_item(KIND_UNUSED, char_t'($urandom), LOAD_W'($urandom));
				else
					send_item(KIND_LOAD, char_t'($urandom), LOAD_W'($urandom));
			end
			send_item(KIND_TEXT, text_q[i], LOAD_W'($urandom));
		end
		send_item(KIND_END, char_t'($urandom), LOAD_W'($urandom));
	endtask

	// Drop valid, wait for every expected result, then let the block drain
	task automatic settle();
		@(negedge clk);
		items_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_found.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write pattern_length over the register port and read it back
	task automatic set_pattern_length(input logic [PLEN_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PATTERN_LENGTH_ADDR;
		pwdata <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pattern_length = value;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(pattern_length)) begin
			$error("pattern_length readback mismatch: expected %0d, actual %0d",
				pattern_length, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result receiver: free-running, sparse stalls, or long stalls
	initial begin
		int mode;
		int mode_left;
		int stall_left;
		mode = 0;
		mode_left = 0;
		stall_left = 0;
		results_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 60);
			end
			mode_left--;
			if (stall_left > 0) begin
				stall_left--;
				results_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: results_ch.ready <= 1'b1;
					1: results_ch.ready <= ($urandom_range(0, 9) >= 3);
					default: begin
						if ($urandom_range(0, 3) == 0) begin
							stall_left = $urandom_range(3, 12);
							results_ch.ready <= 1'b0;
						end else begin
							results_ch.ready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		bit want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (expected_found.size() == 0) begin
				$error("result with no expectation pending: found=%0b", results_ch.found);
				errors++;
			end else begin
				want = expected_found.pop_front();
				results_checked++;
				if (results_ch.found)
					found_count++;
				if (results_ch.found !== want) begin
					$error("found mismatch: expected %0b, actual %0b", want, results_ch.found);
					errors++;
				end
			end
		end
	end

	// Empty pattern reports found, also for an empty text
	task automatic test_empty_pattern();
		char_t none_q[$];
		char_t text_q[$];
		none_q = {};
		send_text(none_q, 1'b0);
		text_q = {8'h00, 8'hFF};
		send_text(text_q, 1'b0);
	endtask

	// A match that ends on the last text byte counts
	task automatic test_match_at_end();
		char_t pat_q[$];
		char_t text_q[$];
		settle();
		set_pattern_length(PLEN_W'(3));
		pat_q = {8'h00, 8'hFF, 8'h41};
		load_pattern(pat_q);
		send_item(KIND_LOAD, 8'hFF, LOAD_W'(PATTERN_MAX - 1));
		text_q = {8'h41, 8'h00, 8'hFF, 8'h41};
		send_text(text_q, 1'b0);
	endtask

	// Too-short text misses; stale window bytes after end of text do not match
	task automatic test_short_and_stale();
		char_t text_q[$];
		text_q = {8'h00, 8'hFF};
		send_text(text_q, 1'b0);
		text_q = {8'h41};
		send_text(text_q, 1'b0);
	endtask

	// Found stays set after the match; an unused kind is dropped
	task automatic test_sticky_and_unused_kind();
		char_t text_q[$];
		text_q = {8'h00, 8'hFF, 8'h41, 8'h7E, 8'h7E};
		send_text(text_q, 1'b0);
		send_item(KIND_TEXT, 8'h00, '0);
		send_item(KIND_UNUSED, 8'hFF, LOAD_W'(PATTERN_MAX - 1));
		send_item(KIND_TEXT, 8'hFF, '0);
		send_item(KIND_TEXT, 8'h41, '0);
		send_item(KIND_END, 8'h00, '0);
	endtask

	// Length beyond the store never matches; single byte pattern does
	task automatic test_length_extremes();
		char_t pat_q[$];
		char_t text_q[$];
		settle();
		set_pattern_length(PLEN_W'(PATTERN_MAX + 1));
		text_q = {8'h00, 8'hFF, 8'h41};
		send_text(text_q, 1'b0);
		settle();
		set_pattern_length(PLEN_W'(1));
		pat_q = {8'h80};
		load_pattern(pat_q);
		text_q = {8'h80};
		send_text(text_q, 1'b0);
	endtask

	// Random phases: new length and pattern, then texts, some with planted matches
	task automatic test_random_search();
		int start_items;
		int plen;
		int n_texts;
		int span;
		int n;
		int pos;
		int i;
		int k;
		bit narrow;
		char_t sym_a;
		char_t sym_b;
		char_t pat_q[$];
		char_t text_q[$];
		start_items = items_sent;
		while (items_sent - start_items < RANDOM_ITEMS) begin
			settle();
			case ($urandom_range(0, 9))
				0: plen = 0;
				1: plen = PATTERN_MAX;
				2: plen = 1;
				3: plen = $urandom_range(9, PATTERN_MAX);
				default: plen = $urandom_range(2, 8);
			endcase
			set_pattern_length(PLEN_W'(plen));
			narrow = ($urandom_range(0, 4) < 3);
			sym_a = char_t'($urandom);
			sym_b = char_t'($urandom);
			pat_q = {};
			for (i = 0; i < plen; i++)
				pat_q.push_back(narrow ? ($urandom_range(0, 1) ? sym_a : sym_b)
					: char_t'($urandom));
			load_pattern(pat_q);
			n_texts = (plen > 16) ? $urandom_range(1, 2) : $urandom_range(1, 4);
			span = (plen + 8 > 12) ? plen + 8 : 12;
			for (k = 0; k < n_texts; k++) begin
				n = $urandom_range(0, span);
				text_q = {};
				for (i = 0; i < n; i++)
					text_q.push_back(narrow ? ($urandom_range(0, 1) ? sym_a : sym_b)
						: char_t'($urandom));
				// Plant the current pattern, often right at the end
				if (plen > 0 && n >= plen && $urandom_range(0, 1) == 1) begin
					pos = ($urandom_range(0, 2) == 0) ? n - plen : $urandom_range(0, n - plen);
					for (i = 0; i < plen; i++)
						text_q[pos + i] = pattern_mem[i];
				end
				send_text(text_q, 1'b1);
			end
		end
	endtask

	// Stimulus
	initial begin
		errors = 0;
		items_sent = 0;
		texts_closed = 0;
		results_checked = 0;
		found_count = 0;
		burst_left = 0;
		chars_seen = 0;
		match_seen = 1'b0;
		pattern_length = '0;
		foreach (text_window[i]) text_window[i] = '0;
		foreach (pattern_mem[i]) pattern_mem[i] = '0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		items_ch.valid = 1'b0;
		items_ch.kind = KIND_LOAD;
		items_ch.char_value = '0;
		items_ch.load_index = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_pattern();
		test_match_at_end();
		test_short_and_stale();
		test_sticky_and_unused_kind();
		test_length_extremes();
		test_random_search();
		settle();

		$display("Sent %0d items over %0d texts with pattern lengths 0 to %0d and beyond;",
			items_sent, texts_closed, PATTERN_MAX);
		$display("checked %0d results, %0d of them reporting a match.",
			results_checked, found_count);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
